FILE: rtl/core/s3c_pkg.sv
// Shared constants, types and register codes for the 3x3 RGB convolution block.
`timescale 1ns / 1ps
package s3c_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_DIM      = 3;
   localparam int PIX_W        = 8;
   localparam int NUM_CHAN     = 3;
   localparam int PIX_BITS     = PIX_W * NUM_CHAN;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int WEIGHT_W     = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int SUM4_W       = PIX_W + 2;
   localparam int PROD_W       = SUM4_W + 1 + WEIGHT_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int FRAC_W       = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = QPTR_W + 1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_WEIGHT_CORNER = 3'd2,
      REG_WEIGHT_SIDE   = 3'd3,
      REG_WEIGHT_MIDDLE = 3'd4
   } csr_index_type;

   // effective (clamped) dimensions and kernel weights
   typedef struct packed {
      logic [WIDTH_REG_W-1:0]    width;
      logic [HEIGHT_REG_W-1:0]   height;
      logic signed [WEIGHT_W-1:0] w_corner;
      logic signed [WEIGHT_W-1:0] w_side;
      logic signed [WEIGHT_W-1:0] w_middle;
   } cfg_type;

   typedef struct packed {
      logic [SUM4_W-1:0] corners;
      logic [SUM4_W-1:0] sides;
      logic [PIX_W-1:0]  center;
   } chan_sums_type;

   // one classified window, ready for the multiply stage
   typedef struct packed {
      chan_sums_type [NUM_CHAN-1:0] sums;
      logic [ROW_W-1:0]             row;
      logic [COL_W-1:0]             col;
      logic                         done;
   } work_type;

endpackage

FILE: rtl/core/s3c_if.sv
// Channel interfaces: pixel requests, filtered responses and register writes.
`timescale 1ns / 1ps
interface s3c_req_if;
   import s3c_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] chan0_in;
   logic [PIX_W-1:0] chan1_in;
   logic [PIX_W-1:0] chan2_in;
   modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                   input ready);
   modport sink   (input valid, input chan0_in, input chan1_in, input chan2_in,
                   output ready);
endinterface

interface s3c_rsp_if;
   import s3c_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] chan0_out;
   logic [PIX_W-1:0] chan1_out;
   logic [PIX_W-1:0] chan2_out;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic             frame_done;
   modport source (output valid, output chan0_out, output chan1_out, output chan2_out,
                   output out_row, output out_col, output frame_done, input ready);
   modport sink   (input valid, input chan0_out, input chan1_out, input chan2_out,
                   input out_row, input out_col, input frame_done, output ready);
endinterface

interface s3c_csr_if;
   import s3c_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/symmetric_3x3_convolution_rgb.sv
// Top level of the symmetric 3x3 RGB convolution filter.
//
// Pixels enter on req_bus in raster order, one transaction per pixel with the
// three 8-bit channels. For every interior pixel (not on the one-pixel frame
// border) one transaction leaves on rsp_bus: the three filtered channels,
// clamped to 0..255, the pixel's row and column, and frame_done on the last
// interior pixel of the frame. Border pixels produce no response.
// Registers are written over csr_bus (index 0 width, 1 height, 2..4 corner,
// side and center weights in signed Q8.8); writing a dimension restarts the
// frame. Writes are taken in any cycle but must only be issued while idle.
// Throughput is one pixel per cycle while req_bus.ready stays high. The pixel
// that completes a window reaches rsp_bus through the line-store read, the window
// update, the weight multiplies and the sum/clamp stage.
// A 4-entry queue separates the window front end from the multiply back end,
// so a stalled receiver stops rsp_bus first and req_bus.ready drops once
// queued entries plus the window stage reach the queue depth. Reset clears the
// counters, window and pipeline and loads the default registers (512 x 512,
// sharpening kernel); the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module symmetric_3x3_convolution_rgb (
   input  logic      clock,
   input  logic      reset,
   s3c_req_if.sink   req_bus,
   s3c_rsp_if.source rsp_bus,
   s3c_csr_if.sink   csr_bus
);
   import s3c_pkg::*;

   logic [WIDTH_REG_W-1:0]     width_ff;
   logic [HEIGHT_REG_W-1:0]    height_ff;
   logic signed [WEIGHT_W-1:0] w_corner_ff, w_side_ff, w_middle_ff;
   logic                       csr_write;
   logic                       restart;
   cfg_type                    cfg;

   logic                       push, pop, q_not_empty;
   work_type                   push_data, pop_data;
   logic [QCNT_W-1:0]          q_count;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_REG_W'(512);
         height_ff   <= HEIGHT_REG_W'(512);
         w_corner_ff <= WEIGHT_W'(0);
         w_side_ff   <= -WEIGHT_W'(256);
         w_middle_ff <= WEIGHT_W'(1280);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_bus.index))
            REG_IMAGE_WIDTH:   width_ff    <= csr_bus.data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT:  height_ff   <= csr_bus.data[HEIGHT_REG_W-1:0];
            REG_WEIGHT_CORNER: w_corner_ff <= csr_bus.data;
            REG_WEIGHT_SIDE:   w_side_ff   <= csr_bus.data;
            REG_WEIGHT_MIDDLE: w_middle_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign restart = csr_write &&
                    ((csr_index_type'(csr_bus.index) == REG_IMAGE_WIDTH) ||
                     (csr_index_type'(csr_bus.index) == REG_IMAGE_HEIGHT));

   // dimensions in use are clamped to the supported frame size
   always_comb begin
      if (width_ff < WIDTH_REG_W'(MIN_DIM)) begin
         cfg.width = WIDTH_REG_W'(MIN_DIM);
      end else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         cfg.width = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff < HEIGHT_REG_W'(MIN_DIM)) begin
         cfg.height = HEIGHT_REG_W'(MIN_DIM);
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         cfg.height = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
      cfg.w_corner = w_corner_ff;
      cfg.w_side   = w_side_ff;
      cfg.w_middle = w_middle_ff;
   end

   s3c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data),
      .req_bus   (req_bus)
   );

   s3c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   s3c_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_not_empty),
      .q_data  (pop_data),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );
endmodule

FILE: rtl/core/s3c_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module s3c_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/s3c_front.sv
// Front end: raster counters, line stores, 3x3 window and per-channel tap sums.
`timescale 1ns / 1ps
module s3c_front (
   input  logic                     clock,
   input  logic                     reset,
   input  s3c_pkg::cfg_type         cfg,
   input  logic                     restart,
   input  logic [s3c_pkg::QCNT_W-1:0] q_count,
   output logic                     push,
   output s3c_pkg::work_type        push_data,
   s3c_req_if.sink                  req_bus
);
   import s3c_pkg::*;

   logic [COL_W-1:0]    col_ff, col_in, col_use;
   logic [ROW_W-1:0]    row_ff, row_in, row_use;
   logic [COL_W:0]      col_next;
   logic [ROW_W:0]      row_next;
   logic                accept;

   logic                s1_valid_ff;
   logic                s1_emit_ff;
   logic [COL_W-1:0]    s1_addr_ff;
   logic [PIX_BITS-1:0] s1_pix_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_done_ff;

   logic [PIX_BITS-1:0] up1, up2;
   logic [PIX_BITS-1:0] win_ff [3][3];
   logic [PIX_BITS-1:0] win_in [3][3];

   assign req_bus.ready = (q_count + QCNT_W'(s1_valid_ff)) < QCNT_W'(QUEUE_DEPTH);
   assign accept        = req_bus.valid && req_bus.ready;

   // counters are always below the active dimensions; the guard covers odd corners
   assign col_use = ({1'b0, col_ff} >= cfg.width) ? '0 : col_ff;
   assign row_use = ({1'b0, row_ff} >= cfg.height) ? '0 : row_ff;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      col_next = {1'b0, col_use} + (COL_W+1)'(1);
      row_next = {1'b0, row_use} + (ROW_W+1)'(1);
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (WIDTH_REG_W'(col_next) >= cfg.width) begin
            col_in = '0;
            row_in = (HEIGHT_REG_W'(row_next) >= cfg.height) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= col_use;
         s1_pix_ff  <= {req_bus.chan2_in, req_bus.chan1_in, req_bus.chan0_in};
         s1_emit_ff <= (row_use >= ROW_W'(2)) && (col_use >= COL_W'(2));
         s1_row_ff  <= row_use - ROW_W'(1);
         s1_col_ff  <= col_use - COL_W'(1);
         s1_done_ff <= ({1'b0, row_use} == cfg.height - HEIGHT_REG_W'(1)) &&
                       ({1'b0, col_use} == cfg.width - WIDTH_REG_W'(1));
      end
   end

   // line store a holds the previous row, b the row before that
   s3c_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_use),
      .rd_data (up1)
   );

   s3c_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (up1),
      .rd_en   (accept),
      .rd_addr (col_use),
      .rd_data (up2)
   );

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = up2;
         win_in[1][2] = up1;
         win_in[2][2] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         push_data.sums[k].corners = SUM4_W'(win_in[0][0][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[0][2][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[2][0][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[2][2][PIX_W*k +: PIX_W]);
         push_data.sums[k].sides   = SUM4_W'(win_in[0][1][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[1][0][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[1][2][PIX_W*k +: PIX_W])
                                   + SUM4_W'(win_in[2][1][PIX_W*k +: PIX_W]);
         push_data.sums[k].center  = win_in[1][1][PIX_W*k +: PIX_W];
      end
      push_data.row  = s1_row_ff;
      push_data.col  = s1_col_ff;
      push_data.done = s1_done_ff;
   end

   assign push = s1_valid_ff && s1_emit_ff;

   a_s1_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(accept))
      else $error("window stage holds a transaction that was never accepted");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < cfg.width) && ({1'b0, row_ff} < cfg.height))
      else $error("raster counter outside the active frame");
endmodule

FILE: rtl/core/s3c_queue.sv
// Short FIFO between the window front end and the multiply back end.
`timescale 1ns / 1ps
module s3c_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  s3c_pkg::work_type          push_data,
   input  logic                       pop,
   output s3c_pkg::work_type          pop_data,
   output logic                       not_empty,
   output logic [s3c_pkg::QCNT_W-1:0] count
);
   import s3c_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
endmodule

FILE: rtl/core/s3c_back.sv
// Back end: kernel multiplies, exact sum, truncation, clamp and response register.
`timescale 1ns / 1ps
module s3c_back (
   input  logic              clock,
   input  logic              reset,
   input  s3c_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  s3c_pkg::work_type q_data,
   output logic              pop,
   s3c_rsp_if.source         rsp_bus
);
   import s3c_pkg::*;

   logic                     b1_valid_ff;
   logic signed [PROD_W-1:0] prod_c_ff [NUM_CHAN];
   logic signed [PROD_W-1:0] prod_s_ff [NUM_CHAN];
   logic signed [PROD_W-1:0] prod_m_ff [NUM_CHAN];
   logic [ROW_W-1:0]         b1_row_ff;
   logic [COL_W-1:0]         b1_col_ff;
   logic                     b1_done_ff;

   logic signed [PROD_W-1:0] op_c, op_s, op_m;
   logic signed [PROD_W-1:0] wt_c, wt_s, wt_m;
   logic signed [ACC_W-1:0]  acc [NUM_CHAN];
   logic [PIX_W-1:0]         pix_in [NUM_CHAN];

   logic                     rsp_valid_ff;
   logic [PIX_W-1:0]         out_pix_ff [NUM_CHAN];
   logic [ROW_W-1:0]         out_row_ff;
   logic [COL_W-1:0]         out_col_ff;
   logic                     out_done_ff;

   logic                     out_ready, b1_ready;

   assign out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign b1_ready  = !b1_valid_ff || out_ready;
   assign pop       = q_valid && b1_ready;

   assign wt_c = PROD_W'(cfg.w_corner);
   assign wt_s = PROD_W'(cfg.w_side);
   assign wt_m = PROD_W'(cfg.w_middle);

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            prod_c_ff[k] <= PROD_W'($signed({1'b0, q_data.sums[k].corners})) * wt_c;
            prod_s_ff[k] <= PROD_W'($signed({1'b0, q_data.sums[k].sides})) * wt_s;
            prod_m_ff[k] <= PROD_W'($signed({1'b0, q_data.sums[k].center})) * wt_m;
         end
         b1_row_ff  <= q_data.row;
         b1_col_ff  <= q_data.col;
         b1_done_ff <= q_data.done;
      end
   end

   // exact Q8.8 sum, truncated once; non-negative so a shift truncates toward zero
   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         acc[k] = ACC_W'(prod_c_ff[k]) + ACC_W'(prod_s_ff[k]) + ACC_W'(prod_m_ff[k]);
         if (acc[k][ACC_W-1]) begin
            pix_in[k] = '0;
         end else if (|acc[k][ACC_W-2:FRAC_W+PIX_W]) begin
            pix_in[k] = PIX_MAX;
         end else begin
            pix_in[k] = acc[k][FRAC_W +: PIX_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff && out_ready) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            out_pix_ff[k] <= pix_in[k];
         end
         out_row_ff  <= b1_row_ff;
         out_col_ff  <= b1_col_ff;
         out_done_ff <= b1_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_valid_ff <= q_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= b1_valid_ff;
         end
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.chan0_out  = out_pix_ff[0];
   assign rsp_bus.chan1_out  = out_pix_ff[1];
   assign rsp_bus.chan2_out  = out_pix_ff[2];
   assign rsp_bus.out_row    = out_row_ff;
   assign rsp_bus.out_col    = out_col_ff;
   assign rsp_bus.frame_done = out_done_ff;

   a_b1_holds: assert property (@(posedge clock) disable iff (reset)
      b1_valid_ff && !out_ready |=> b1_valid_ff)
      else $error("multiply stage dropped a transaction under backpressure");
endmodule

FILE: dv/symmetric_3x3_convolution_rgb_test.sv
// Self-checking testbench for the symmetric 3x3 RGB convolution filter.
`timescale 1ns / 1ps
module symmetric_3x3_convolution_rgb_test;
   import s3c_pkg::*;

   localparam int RANDOM_PIXELS = 1200;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RSP_HOLDOFF   = 300;
   localparam int RUN_CAP       = 400;
   localparam int WIDE_COLS     = 160;
   localparam int WIDE_HOLD_AT  = 400;

   // indexes the block has no register behind
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam logic [PIX_W-1:0] BYTE_PATTERNS [8] = '{
      8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE
   };

   typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_SMOOTH} pixel_style_type;

   typedef struct packed {
      logic [PIX_W-1:0] chan0;
      logic [PIX_W-1:0] chan1;
      logic [PIX_W-1:0] chan2;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             done;
   } filtered_type;

   class filter_scoreboard;
      logic [PIX_BITS-1:0]        prev_row [MAX_WIDTH];
      logic [PIX_BITS-1:0]        older_row [MAX_WIDTH];
      logic [PIX_BITS-1:0]        window [3][3];   // [0] oldest row, [*][0] leftmost
      int unsigned                col_pos;
      int unsigned                row_pos;
      logic [WIDTH_REG_W-1:0]     width_reg;
      logic [HEIGHT_REG_W-1:0]    height_reg;
      logic signed [WEIGHT_W-1:0] w_corner;
      logic signed [WEIGHT_W-1:0] w_side;
      logic signed [WEIGHT_W-1:0] w_middle;
      filtered_type               pending_filtered [$];
      int                         failures;

      function new();
         foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
         end
         foreach (window[i, j]) window[i][j] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_REG_W'(512);
         height_reg = HEIGHT_REG_W'(512);
         w_corner   = '0;
         w_side     = -WEIGHT_W'(256);
         w_middle   = WEIGHT_W'(1280);
         failures   = 0;
      endfunction

      function int unsigned used_width();
         if (int'(width_reg) < MIN_DIM) return MIN_DIM;
         if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
         return 32'(width_reg);
      endfunction

      function int unsigned used_height();
         if (int'(height_reg) < MIN_DIM) return MIN_DIM;
         if (int'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
         return 32'(height_reg);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_reg = value[WIDTH_REG_W-1:0];
               col_pos   = 0;
               row_pos   = 0;
            end
            REG_IMAGE_HEIGHT: begin
               height_reg = value[HEIGHT_REG_W-1:0];
               col_pos    = 0;
               row_pos    = 0;
            end
            REG_WEIGHT_CORNER: w_corner = value;
            REG_WEIGHT_SIDE:   w_side   = value;
            REG_WEIGHT_MIDDLE: w_middle = value;
            default: ;
         endcase
      endfunction

      // exact weighted sum, one truncation toward zero, clamp to a byte
      function logic [PIX_W-1:0] filter_channel(int k);
         longint corners;
         longint sides;
         longint center;
         longint acc;
         corners = longint'(window[0][0][k*PIX_W +: PIX_W]) + window[0][2][k*PIX_W +: PIX_W]
                 + window[2][0][k*PIX_W +: PIX_W] + window[2][2][k*PIX_W +: PIX_W];
         sides   = longint'(window[0][1][k*PIX_W +: PIX_W]) + window[1][0][k*PIX_W +: PIX_W]
                 + window[1][2][k*PIX_W +: PIX_W] + window[2][1][k*PIX_W +: PIX_W];
         center  = longint'(window[1][1][k*PIX_W +: PIX_W]);
         acc = corners * longint'(w_corner) + sides * longint'(w_side)
             + center * longint'(w_middle);
         if (acc < 0) return '0;
         acc = acc / 256;
         if (acc > PIX_MAX) return PIX_MAX;
         return acc[PIX_W-1:0];
      endfunction

      function void take_pixel(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                               logic [PIX_W-1:0] c2);
         int unsigned         w;
         int unsigned         h;
         logic [PIX_BITS-1:0] pix;
         logic [PIX_BITS-1:0] up1;
         logic [PIX_BITS-1:0] up2;
         filtered_type        want;
         w = used_width();
         h = used_height();
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         pix = {c2, c1, c0};
         up1 = prev_row[COL_W'(col_pos)];
         up2 = older_row[COL_W'(col_pos)];
         for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
         end
         window[0][2] = up2;
         window[1][2] = up1;
         window[2][2] = pix;
         older_row[COL_W'(col_pos)] = up1;
         prev_row[COL_W'(col_pos)]  = pix;
         if (row_pos >= 2 && col_pos >= 2) begin
            want.chan0 = filter_channel(0);
            want.chan1 = filter_channel(1);
            want.chan2 = filter_channel(2);
            want.row   = ROW_W'(row_pos - 1);
            want.col   = COL_W'(col_pos - 1);
            want.done  = (row_pos == h - 1) && (col_pos == w - 1);
            pending_filtered.push_back(want);
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_filtered(filtered_type got);
         filtered_type want;
         if (pending_filtered.size() == 0) begin
            $error("filtered pixel at row %0d col %0d with nothing outstanding",
                   got.row, got.col);
            failures++;
            return;
         end
         want = pending_filtered.pop_front();
         compare_field("chan0_out", 16'(want.chan0), 16'(got.chan0));
         compare_field("chan1_out", 16'(want.chan1), 16'(got.chan1));
         compare_field("chan2_out", 16'(want.chan2), 16'(got.chan2));
         compare_field("out_row", 16'(want.row), 16'(got.row));
         compare_field("out_col", 16'(want.col), 16'(got.col));
         compare_field("frame_done", 16'(want.done), 16'(got.done));
      endfunction

      function int close_out();
         if (pending_filtered.size() != 0) begin
            $error("%0d filtered pixels never arrived", pending_filtered.size());
            failures += pending_filtered.size();
         end
         return failures;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;       // no random idling on either side while set; a hold-off still applies
   bit   hold_rsp;     // asks the receiver for one long hold-off
   int   pixels_sent;
   int   quiet_cycles;

   filter_scoreboard sb = new();

   s3c_req_if req_bus();
   s3c_rsp_if rsp_bus();
   s3c_csr_if csr_bus();

   symmetric_3x3_convolution_rgb DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [PIX_W-1:0] pick_channel(pixel_style_type style,
                                                     logic [PIX_W-1:0] base);
      case (style)
         PIX_NOISE:   return 8'($urandom);
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:     return base + 8'($urandom_range(0, 15)) - 8'd8;
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] random_weight();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 16'($urandom_range(0, 1024) - 512);
      if (sel < 8) return 16'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_width();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return 16'($urandom_range(3, 12));
      if (sel < 8) return 16'($urandom_range(0, 2));
      if (sel < 9) return 16'($urandom_range(13, 40));
      // junk above the register width is dropped
      return {5'b11111, 11'($urandom_range(3, 8))};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_height();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return 16'($urandom_range(3, 8));
      if (sel < 8) return 16'($urandom_range(0, 2));
      if (sel < 9) return 16'($urandom_range(9, 20));
      return 16'hFFFF;
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] c0, input logic [PIX_W-1:0] c1,
                             input logic [PIX_W-1:0] c2);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 24) gap = $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.chan0_in <= c0;
      req_bus.chan1_in <= c1;
      req_bus.chan2_in <= c2;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_pixel(c0, c1, c2);
      pixels_sent++;
   endtask

   task automatic send_run(input int count, input pixel_style_type style,
                           input int holdoff_at);
      logic [PIX_W-1:0] b0;
      logic [PIX_W-1:0] b1;
      logic [PIX_W-1:0] b2;
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      for (int i = 0; i < count; i++) begin
         if (i == holdoff_at) hold_rsp = 1'b1;
         send_pixel(pick_channel(style, b0), pick_channel(style, b1),
                    pick_channel(style, b2));
      end
   endtask

   // stop offering pixels and let the pipeline empty out
   task automatic pause_pixels();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : response_sink
      int           hold_left;
      filtered_type got;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = RSP_HOLDOFF;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 32);
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.chan0 = rsp_bus.chan0_out;
            got.chan1 = rsp_bus.chan1_out;
            got.chan2 = rsp_bus.chan2_out;
            got.row   = rsp_bus.out_row;
            got.col   = rsp_bus.out_col;
            got.done  = rsp_bus.frame_done;
            sb.check_filtered(got);
         end
      end
   end

   // ends the run if no transaction of any kind completes for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int          phase;
      int          count;
      int unsigned frame;
      int          random_goal;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.chan0_in = '0;
      req_bus.chan1_in = '0;
      req_bus.chan2_in = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      steady           = 1'b0;
      hold_rsp         = 1'b0;
      pixels_sent      = 0;
      quiet_cycles     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest width, default sharpening kernel, byte extremes and bit patterns
      write_csr(REG_IMAGE_WIDTH, 16'd3);
      write_csr(REG_IMAGE_HEIGHT, 16'd5);
      for (int i = 0; i < 15; i++) begin
         send_pixel(BYTE_PATTERNS[i % 8], BYTE_PATTERNS[(i + 3) % 8],
                    BYTE_PATTERNS[(i * 5) % 8]);
      end
      pause_pixels();

      // dimensions below the minimum, extreme weights, writes to spare indexes
      write_csr(REG_IMAGE_WIDTH, 16'd0);
      write_csr(REG_IMAGE_HEIGHT, 16'd1);
      write_csr(REG_WEIGHT_CORNER, 16'h8000);
      write_csr(REG_WEIGHT_SIDE, 16'h7FFF);
      write_csr(REG_WEIGHT_MIDDLE, 16'h7FFF);
      write_csr(CSR_SPARE_FIRST, 16'hFFFF);
      write_csr(CSR_SPARE_LAST, 16'h1234);
      for (int i = 0; i < 9; i++) begin
         if (i % 2 == 0) send_pixel(8'hFF, 8'hFF, 8'hFF);
         else send_pixel(8'h00, 8'h00, 8'h00);
      end
      pause_pixels();

      // wide frame with a unity-gain blur; the receiver stalls long in the middle of it
      write_csr(REG_IMAGE_WIDTH, 16'(WIDE_COLS));
      write_csr(REG_IMAGE_HEIGHT, 16'd3);
      write_csr(REG_WEIGHT_CORNER, 16'd16);
      write_csr(REG_WEIGHT_SIDE, 16'd32);
      write_csr(REG_WEIGHT_MIDDLE, 16'd64);
      steady = 1'b1;
      send_run(3 * WIDE_COLS, PIX_NOISE, WIDE_HOLD_AT);
      steady = 1'b0;
      pause_pixels();

      random_goal = pixels_sent + RANDOM_PIXELS;
      phase = 0;
      while (pixels_sent < random_goal) begin
         phase++;
         steady = (phase % 7 == 3);
         pause_pixels();
         if ($urandom_range(0, 1)) write_csr(REG_IMAGE_WIDTH, random_width());
         if ($urandom_range(0, 1)) write_csr(REG_IMAGE_HEIGHT, random_height());
         if ($urandom_range(0, 1)) write_csr(REG_WEIGHT_CORNER, random_weight());
         if ($urandom_range(0, 1)) write_csr(REG_WEIGHT_SIDE, random_weight());
         if ($urandom_range(0, 1)) write_csr(REG_WEIGHT_MIDDLE, random_weight());
         if ($urandom_range(0, 9) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_FIRST : CSR_SPARE_LAST,
                      16'($urandom));
         end
         frame = sb.used_width() * sb.used_height();
         case ($urandom_range(0, 4))
            0, 1:    count = int'(frame * $urandom_range(1, 2));
            2:       count = int'($urandom_range(1, 3));
            default: count = int'($urandom_range(1, frame));
         endcase
         if (count > RUN_CAP) count = RUN_CAP;
         send_run(count, pixel_style_type'($urandom_range(0, 2)), -1);
      end
      steady = 1'b0;
      pause_pixels();

      if (sb.close_out() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
